// ===== rtl/lfor_pkg.sv =====
package lfor_pkg;

    localparam int unsigned DistW  = 10;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned SpeedW = 10;
    localparam int unsigned StepW  = 8;
    localparam int unsigned HoldW  = 16;
    localparam int unsigned PinsW  = 4;
    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 16;

    // h-bridge patterns, IN1..IN4 at bits 0..3
    localparam logic [PinsW-1:0] PINS_STOP  = 4'h0;
    localparam logic [PinsW-1:0] PINS_FWD   = 4'hA;
    localparam logic [PinsW-1:0] PINS_LEFT  = 4'h9;
    localparam logic [PinsW-1:0] PINS_RIGHT = 4'h6;

    // configuration register indexes
    localparam logic [CfgAddrW-1:0] REG_SLOW_DISTANCE    = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_RAMP_INTERVAL_MS = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_RAMP_STEP        = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_CLEAR_HOLD_MS    = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_FULL_SPEED       = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_HARD_TURN_SPEED  = 3'd5;
    localparam logic [CfgAddrW-1:0] REG_RECOVER_SPEED    = 3'd6;
    localparam logic [CfgAddrW-1:0] REG_SOFT_TURN_SPEED  = 3'd7;

    // line sensor codes {left, center, right}
    localparam logic [2:0] SENSE_NONE         = 3'b000;
    localparam logic [2:0] SENSE_RIGHT        = 3'b001;
    localparam logic [2:0] SENSE_CENTER       = 3'b010;
    localparam logic [2:0] SENSE_CENTER_RIGHT = 3'b011;
    localparam logic [2:0] SENSE_LEFT         = 3'b100;
    localparam logic [2:0] SENSE_LEFT_RIGHT   = 3'b101;
    localparam logic [2:0] SENSE_LEFT_CENTER  = 3'b110;
    localparam logic [2:0] SENSE_ALL          = 3'b111;

    typedef enum logic [1:0] {
        MV_NONE  = 2'd0,
        MV_FWD   = 2'd1,
        MV_LEFT  = 2'd2,
        MV_RIGHT = 2'd3
    } t_move;

    // result item, pwm_compare in the lowest bits
    typedef struct packed {
        logic              is_active;
        logic              brake_first;
        logic [PinsW-1:0]  bridge_pins;
        logic [SpeedW-1:0] pwm_compare;
    } t_result;

    typedef struct packed {
        logic [SpeedW-1:0] pwm;
        logic [PinsW-1:0]  pins;
        logic              brake;
        logic              set_move;
        t_move             move;
    } t_line_dec;

    // sensor-case table for normal line following
    function automatic t_line_dec line_decode(
        input logic [2:0]        code,
        input logic              moved,
        input t_move             last_move,
        input logic [SpeedW-1:0] full_speed,
        input logic [SpeedW-1:0] hard_speed,
        input logic [SpeedW-1:0] recover_speed,
        input logic [SpeedW-1:0] soft_speed
    );
        t_line_dec d;
        d = '{pwm: '0, pins: PINS_STOP, brake: 1'b0, set_move: 1'b0, move: MV_NONE};
        case (code)
            SENSE_NONE: begin
                if (moved) begin
                    case (last_move)
                        MV_FWD: begin
                            d.pwm  = recover_speed;
                            d.pins = PINS_FWD;
                        end
                        MV_LEFT: begin
                            d.pwm  = hard_speed;
                            d.pins = PINS_LEFT;
                        end
                        MV_RIGHT: begin
                            d.pwm  = hard_speed;
                            d.pins = PINS_RIGHT;
                        end
                        default: ;
                    endcase
                end
            end
            SENSE_CENTER, SENSE_ALL: begin
                d.pwm      = full_speed;
                d.pins     = PINS_FWD;
                d.set_move = 1'b1;
                d.move     = MV_FWD;
            end
            SENSE_LEFT_CENTER: begin
                d.pwm      = soft_speed;
                d.pins     = PINS_FWD;
                d.set_move = 1'b1;
                d.move     = MV_RIGHT;
            end
            SENSE_LEFT: begin
                d.pwm      = hard_speed;
                d.pins     = PINS_RIGHT;
                d.brake    = (last_move == MV_FWD);
                d.set_move = 1'b1;
                d.move     = MV_RIGHT;
            end
            SENSE_RIGHT: begin
                d.pwm      = hard_speed;
                d.pins     = PINS_LEFT;
                d.brake    = (last_move == MV_FWD);
                d.set_move = 1'b1;
                d.move     = MV_LEFT;
            end
            SENSE_CENTER_RIGHT: begin
                d.pwm      = soft_speed;
                d.pins     = PINS_FWD;
                d.set_move = 1'b1;
                d.move     = MV_LEFT;
            end
            default: ; // left and right black, center white: stop
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/line_follow_obstacle_ramp_controller.sv =====
// channel   | direction | handshake                         | payload
// ----------+-----------+-----------------------------------+-------------------------------
// s_axis    | in        | i_s_axis_tvalid / o_s_axis_tready | one control-loop pass per item
// m_axis    | out       | o_m_axis_tvalid / i_m_axis_tready | one drive command per item
// cfg       | in        | i_cfg_we (no wait, no read-back)  | i_cfg_addr, i_cfg_data
//
// one item per cycle sustained while the output does not stall; each item passes
// the input register, then the pass logic feeding a result register
// the loop-carried state (speed, stamps, flags) updates in the same cycle as the pass
// i_rst_n is synchronous, active low; it clears the state and loads register defaults
// a two-entry output (result register plus skid) keeps input ready off the output stall path

module line_follow_obstacle_ramp_controller
    import lfor_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // [0] button_toggle, [1] sense_left, [2] sense_center, [3] sense_right,
    // [13:4] distance_cm, [45:14] now_ms, [47:46] zero
    input  logic [47:0]         i_s_axis_tdata,

    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [9:0] pwm_compare, [13:10] bridge_pins, [14] brake_first, [15] is_active
    output logic [15:0]         o_m_axis_tdata,

    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    // configuration registers
    logic [DistW-1:0]  r_slow_distance;
    logic [9:0]        r_ramp_interval;
    logic [StepW-1:0]  r_ramp_step;
    logic [HoldW-1:0]  r_clear_hold;
    logic [SpeedW-1:0] r_full_speed;
    logic [SpeedW-1:0] r_hard_speed;
    logic [SpeedW-1:0] r_recover_speed;
    logic [SpeedW-1:0] r_soft_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_distance <= 10'd20;
            r_ramp_interval <= 10'd8;
            r_ramp_step     <= 8'd8;
            r_clear_hold    <= 16'd150;
            r_full_speed    <= 10'd360;
            r_hard_speed    <= 10'd460;
            r_recover_speed <= 10'd350;
            r_soft_speed    <= 10'd420;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SLOW_DISTANCE:    r_slow_distance <= i_cfg_data[DistW-1:0];
                REG_RAMP_INTERVAL_MS: r_ramp_interval <= i_cfg_data[9:0];
                REG_RAMP_STEP:        r_ramp_step     <= i_cfg_data[StepW-1:0];
                REG_CLEAR_HOLD_MS:    r_clear_hold    <= i_cfg_data[HoldW-1:0];
                REG_FULL_SPEED:       r_full_speed    <= i_cfg_data[SpeedW-1:0];
                REG_HARD_TURN_SPEED:  r_hard_speed    <= i_cfg_data[SpeedW-1:0];
                REG_RECOVER_SPEED:    r_recover_speed <= i_cfg_data[SpeedW-1:0];
                REG_SOFT_TURN_SPEED:  r_soft_speed    <= i_cfg_data[SpeedW-1:0];
                default: ;
            endcase
        end
    end

    // input register stage
    logic              r_a_valid;
    logic              r_a_toggle;
    logic [2:0]        r_a_code;      // {left, center, right}
    logic [DistW-1:0]  r_a_dist;
    logic [TimeW-1:0]  r_a_now;

    logic              r_out_valid;
    t_result           r_out_data;
    logic              r_skid_valid;
    t_result           r_skid_data;

    logic              a_fire;
    logic              in_fire;
    logic              out_pop;

    // the pass may retire whenever the skid slot is free
    assign a_fire          = r_a_valid && !r_skid_valid;
    assign o_s_axis_tready = !r_a_valid || !r_skid_valid;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_pop         = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_fire) begin
            r_a_valid <= 1'b1;
        end else if (a_fire) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_toggle <= i_s_axis_tdata[0];
            r_a_code   <= {i_s_axis_tdata[1], i_s_axis_tdata[2], i_s_axis_tdata[3]};
            r_a_dist   <= i_s_axis_tdata[13:4];
            r_a_now    <= i_s_axis_tdata[45:14];
        end
    end

    // loop state
    logic              r_active;
    logic              r_moved;
    t_move             r_last_move;
    logic              r_obstacle;
    logic [TimeW-1:0]  r_clear_stamp;
    logic [TimeW-1:0]  r_ramp_stamp;
    logic [SpeedW-1:0] r_speed;

    logic              n_active;
    logic              n_moved;
    t_move             n_last_move;
    logic              n_obstacle;
    logic [TimeW-1:0]  n_clear_stamp;
    logic [TimeW-1:0]  n_ramp_stamp;
    logic [SpeedW-1:0] n_speed;
    t_result           pass_result;

    logic [TimeW-1:0]  ramp_elapsed;
    logic [TimeW-1:0]  clear_elapsed;
    logic              ramp_due;
    logic              in_hold;
    logic              near;
    logic [SpeedW-1:0] down_speed;
    logic [SpeedW:0]   up_sum;
    logic [SpeedW-1:0] up_speed;
    t_line_dec         line_dec;

    // timestamp differences wrap modulo 2^32
    assign ramp_elapsed  = r_a_now - r_ramp_stamp;
    assign clear_elapsed = r_a_now - r_clear_stamp;
    assign ramp_due      = ramp_elapsed >= {22'd0, r_ramp_interval};
    assign in_hold       = clear_elapsed < {16'd0, r_clear_hold};
    assign near          = r_a_dist < r_slow_distance;

    // step down floors at zero, step up clamps to full speed
    assign down_speed = (r_speed > {2'd0, r_ramp_step}) ? r_speed - {2'd0, r_ramp_step} : '0;
    assign up_sum     = {1'b0, r_speed} + {3'd0, r_ramp_step};
    assign up_speed   = (up_sum < {1'b0, r_full_speed}) ? up_sum[SpeedW-1:0] : r_full_speed;

    assign line_dec = line_decode(r_a_code, r_moved, r_last_move, r_full_speed,
                                  r_hard_speed, r_recover_speed, r_soft_speed);

    always_comb begin
        n_active      = r_active ^ r_a_toggle;
        n_moved       = r_moved;
        n_last_move   = r_last_move;
        n_obstacle    = r_obstacle;
        n_clear_stamp = r_clear_stamp;
        n_ramp_stamp  = r_ramp_stamp;
        n_speed       = r_speed;
        pass_result   = '{is_active: n_active, brake_first: 1'b0,
                          bridge_pins: PINS_STOP, pwm_compare: '0};

        if (!n_active) begin
            // idle: stop, nothing else moves
        end else if (near) begin
            // obstacle close: ramp down, forward until speed reaches zero
            n_obstacle    = 1'b1;
            n_clear_stamp = r_a_now;
            if (ramp_due) begin
                n_ramp_stamp = r_a_now;
                n_speed      = down_speed;
            end
            if (n_speed != '0) begin
                pass_result.pwm_compare = n_speed;
                pass_result.bridge_pins = PINS_FWD;
            end
        end else if (r_obstacle) begin
            // obstacle gone: hold stop, then ramp back up to full speed
            if (!in_hold) begin
                if (ramp_due) begin
                    n_ramp_stamp = r_a_now;
                    n_speed      = up_speed;
                end
                pass_result.pwm_compare = n_speed;
                pass_result.bridge_pins = PINS_FWD;
                if (n_speed >= r_full_speed) begin
                    n_obstacle = 1'b0;
                end
            end
        end else begin
            // normal line following
            n_speed                 = r_full_speed;
            pass_result.pwm_compare = line_dec.pwm;
            pass_result.bridge_pins = line_dec.pins;
            pass_result.brake_first = line_dec.brake;
            if (line_dec.set_move) begin
                n_moved     = 1'b1;
                n_last_move = line_dec.move;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_moved       <= 1'b0;
            r_last_move   <= MV_NONE;
            r_obstacle    <= 1'b0;
            r_clear_stamp <= '0;
            r_ramp_stamp  <= '0;
            r_speed       <= '0;
        end else if (a_fire) begin
            r_active      <= n_active;
            r_moved       <= n_moved;
            r_last_move   <= n_last_move;
            r_obstacle    <= n_obstacle;
            r_clear_stamp <= n_clear_stamp;
            r_ramp_stamp  <= n_ramp_stamp;
            r_speed       <= n_speed;
        end
    end

    // result register with a skid slot behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_pop) begin
                r_out_valid  <= r_skid_valid || a_fire;
                r_skid_valid <= 1'b0;
            end else if (a_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (a_fire) begin
                r_out_data <= pass_result;
            end
        end else if (a_fire) begin
            r_skid_data <= pass_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // the skid slot only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot valid without a result in the output register");

    // an idle result always commands stop
    a_idle_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[15]) |-> (o_m_axis_tdata[14:0] == 15'd0))
        else $error("idle result does not command stop");

    // brake comes only ahead of a pivot turn
    a_brake_on_pivot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[14]) |->
        (o_m_axis_tdata[13:10] == PINS_LEFT || o_m_axis_tdata[13:10] == PINS_RIGHT))
        else $error("brake flagged without a pivot turn");

    // a recorded move implies the moved flag
    a_move_needs_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_moved |-> (r_last_move == MV_NONE))
        else $error("last move recorded while moved flag is clear");

    // a stalled result never gets overwritten by a new pass
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result changed");

endmodule

// ===== tb/line_follow_obstacle_ramp_controller_tb.sv =====
`timescale 1ns / 1ps

module line_follow_obstacle_ramp_controller_tb
    import lfor_pkg::*;
;

    // one control-loop pass, laid out exactly as the input item on the bus:
    // [0] toggle, [1] left, [2] center, [3] right, [13:4] dist_cm, [45:14] now_ms
    typedef struct packed {
        logic [TimeW-1:0] now_ms;
        logic [DistW-1:0] dist_cm;
        logic             right;
        logic             center;
        logic             left;
        logic             toggle;
    } t_pass;

    // kinds of stretches the random stimulus is built from
    typedef enum logic [1:0] {
        EP_LINE  = 2'd0,
        EP_NEAR  = 2'd1,
        EP_NOISE = 2'd2
    } t_episode;

    localparam int unsigned CycleLimit  = 500000;
    localparam int unsigned PhaseCount  = 6;
    localparam int unsigned PhaseItems  = 190;
    localparam int unsigned ReportLimit = 40;

    // predicts the drive command of every pass and checks the commands in order
    class drive_command_board;
        // register copies
        logic [SpeedW-1:0] slow_dist;
        logic [SpeedW-1:0] ramp_gap;
        logic [StepW-1:0]  ramp_inc;
        logic [HoldW-1:0]  hold_ms;
        logic [SpeedW-1:0] full_pwm;
        logic [SpeedW-1:0] hard_pwm;
        logic [SpeedW-1:0] recover_pwm;
        logic [SpeedW-1:0] soft_pwm;
        // controller state
        logic              active;
        logic              moved;
        t_move             last_mv;
        logic              obstacle;
        logic [TimeW-1:0]  clear_at;
        logic [TimeW-1:0]  ramp_at;
        logic [SpeedW-1:0] speed;

        t_result     pending_cmds[$];
        int unsigned errors;
        int unsigned n_checked;
        int unsigned n_idle;
        int unsigned n_near;
        int unsigned n_hold;
        int unsigned n_rise;
        int unsigned n_brake;

        function new();
            slow_dist   = 10'd20;
            ramp_gap    = 10'd8;
            ramp_inc    = 8'd8;
            hold_ms     = 16'd150;
            full_pwm    = 10'd360;
            hard_pwm    = 10'd460;
            recover_pwm = 10'd350;
            soft_pwm    = 10'd420;
            active      = 1'b0;
            moved       = 1'b0;
            last_mv     = MV_NONE;
            obstacle    = 1'b0;
            clear_at    = '0;
            ramp_at     = '0;
            speed       = '0;
            errors      = 0;
            n_checked   = 0;
            n_idle      = 0;
            n_near      = 0;
            n_hold      = 0;
            n_rise      = 0;
            n_brake     = 0;
        endfunction

        function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
            case (idx)
                REG_SLOW_DISTANCE:    slow_dist   = val[SpeedW-1:0];
                REG_RAMP_INTERVAL_MS: ramp_gap    = val[SpeedW-1:0];
                REG_RAMP_STEP:        ramp_inc    = val[StepW-1:0];
                REG_CLEAR_HOLD_MS:    hold_ms     = val[HoldW-1:0];
                REG_FULL_SPEED:       full_pwm    = val[SpeedW-1:0];
                REG_HARD_TURN_SPEED:  hard_pwm    = val[SpeedW-1:0];
                REG_RECOVER_SPEED:    recover_pwm = val[SpeedW-1:0];
                REG_SOFT_TURN_SPEED:  soft_pwm    = val[SpeedW-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return pending_cmds.size();
        endfunction

        // work out the command for one accepted pass and advance the state
        function void note_pass(t_pass p);
            t_result    cmd;
            logic [2:0] code;
            logic [TimeW-1:0] up;
            code = {p.left, p.center, p.right};
            if (p.toggle)
                active = !active;
            cmd.pwm_compare = '0;
            cmd.bridge_pins = PINS_STOP;
            cmd.brake_first = 1'b0;
            cmd.is_active   = active;
            if (!active) begin
                n_idle++;
            end else if (p.dist_cm < slow_dist) begin
                // obstacle near: step the speed down, floor at zero
                n_near++;
                obstacle = 1'b1;
                clear_at = p.now_ms;
                if (p.now_ms - ramp_at >= ramp_gap) begin
                    ramp_at = p.now_ms;
                    speed   = (speed > ramp_inc) ? speed - ramp_inc : '0;
                end
                if (speed != 0) begin
                    cmd.pwm_compare = speed;
                    cmd.bridge_pins = PINS_FWD;
                end
            end else if (obstacle) begin
                if (p.now_ms - clear_at < hold_ms) begin
                    n_hold++;
                end else begin
                    // ramp back up toward full speed, wrapping time difference
                    n_rise++;
                    if (p.now_ms - ramp_at >= ramp_gap) begin
                        up      = speed + ramp_inc;
                        ramp_at = p.now_ms;
                        speed   = (up < full_pwm) ? up[SpeedW-1:0] : full_pwm;
                    end
                    cmd.pwm_compare = speed;
                    cmd.bridge_pins = PINS_FWD;
                    if (speed >= full_pwm)
                        obstacle = 1'b0;
                end
            end else begin
                speed = full_pwm;
                case (code)
                    SENSE_NONE: begin
                        if (moved) begin
                            case (last_mv)
                                MV_FWD: begin
                                    cmd.pwm_compare = recover_pwm;
                                    cmd.bridge_pins = PINS_FWD;
                                end
                                MV_LEFT: begin
                                    cmd.pwm_compare = hard_pwm;
                                    cmd.bridge_pins = PINS_LEFT;
                                end
                                MV_RIGHT: begin
                                    cmd.pwm_compare = hard_pwm;
                                    cmd.bridge_pins = PINS_RIGHT;
                                end
                                default: ;
                            endcase
                        end
                    end
                    SENSE_CENTER, SENSE_ALL: begin
                        cmd.pwm_compare = full_pwm;
                        cmd.bridge_pins = PINS_FWD;
                        moved   = 1'b1;
                        last_mv = MV_FWD;
                    end
                    SENSE_LEFT_CENTER: begin
                        cmd.pwm_compare = soft_pwm;
                        cmd.bridge_pins = PINS_FWD;
                        moved   = 1'b1;
                        last_mv = MV_RIGHT;
                    end
                    SENSE_CENTER_RIGHT: begin
                        cmd.pwm_compare = soft_pwm;
                        cmd.bridge_pins = PINS_FWD;
                        moved   = 1'b1;
                        last_mv = MV_LEFT;
                    end
                    SENSE_LEFT: begin
                        cmd.pwm_compare = hard_pwm;
                        cmd.bridge_pins = PINS_RIGHT;
                        cmd.brake_first = (last_mv == MV_FWD);
                        moved   = 1'b1;
                        last_mv = MV_RIGHT;
                    end
                    SENSE_RIGHT: begin
                        cmd.pwm_compare = hard_pwm;
                        cmd.bridge_pins = PINS_LEFT;
                        cmd.brake_first = (last_mv == MV_FWD);
                        moved   = 1'b1;
                        last_mv = MV_LEFT;
                    end
                    default: ;
                endcase
                if (cmd.brake_first)
                    n_brake++;
            end
            pending_cmds.push_back(cmd);
        endfunction

        function void report(string what, int unsigned want, int unsigned got);
            if (errors < ReportLimit)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        endfunction

        function void check_cmd(t_result got);
            t_result want;
            if (pending_cmds.size() == 0) begin
                if (errors < ReportLimit)
                    $display("%0t: command with none expected, expected nothing, actual %h",
                             $time, got);
                errors++;
                return;
            end
            want = pending_cmds.pop_front();
            n_checked++;
            if (got.pwm_compare !== want.pwm_compare)
                report("pwm_compare", want.pwm_compare, got.pwm_compare);
            if (got.bridge_pins !== want.bridge_pins)
                report("bridge_pins", want.bridge_pins, got.bridge_pins);
            if (got.brake_first !== want.brake_first)
                report("brake_first", want.brake_first, got.brake_first);
            if (got.is_active !== want.is_active)
                report("is_active", want.is_active, got.is_active);
        endfunction
    endclass

    // all block inputs start at known values
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    // [0] button_toggle, [1] sense_left, [2] sense_center, [3] sense_right,
    // [13:4] distance_cm, [45:14] now_ms, [47:46] zero
    logic [47:0]         i_s_axis_tdata  = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    // [9:0] pwm_compare, [13:10] bridge_pins, [14] brake_first, [15] is_active
    logic [15:0]         o_m_axis_tdata;
    logic                i_cfg_we        = 1'b0;
    logic [CfgAddrW-1:0] i_cfg_addr      = '0;
    logic [CfgDataW-1:0] i_cfg_data      = '0;

    drive_command_board cmds;

    // idle shaping: a calm side never idles, otherwise an idle gap is drawn anew for each item
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    // random stimulus state: current stretch kind, its length and the ms clock
    t_episode    episode = EP_LINE;
    int unsigned ep_left = 0;
    logic [TimeW-1:0] clock_ms = '0;
    int unsigned cycle_count = 0;

    line_follow_obstacle_ramp_controller DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog, far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("%0t: run timed out with %0d commands outstanding",
                     $time, cmds.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_pass pass_of(input logic tog, input logic [2:0] lcr,
                                      input logic [DistW-1:0] range_cm,
                                      input logic [TimeW-1:0] stamp);
        t_pass p;
        p.toggle  = tog;
        {p.left, p.center, p.right} = lcr;
        p.dist_cm = range_cm;
        p.now_ms  = stamp;
        return p;
    endfunction

    // random pass: mostly stretches of line following or closing in on an
    // obstacle (clear passes after a near stretch then exercise the hold and
    // ramp-up), with short bursts of fully random noise
    function automatic t_pass random_pass();
        t_pass       p;
        int unsigned roll;
        int unsigned near_max;
        if (ep_left == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                episode = EP_LINE;
                ep_left = $urandom_range(4, 30);
            end else if (roll < 88) begin
                episode = EP_NEAR;
                ep_left = $urandom_range(2, 25);
            end else begin
                episode = EP_NOISE;
                ep_left = $urandom_range(1, 4);
            end
        end
        ep_left--;

        // ms clock: small steps mostly, sometimes long gaps or a jump anywhere
        roll = $urandom_range(0, 99);
        if (roll < 80)
            clock_ms += $urandom_range(0, 24);
        else if (roll < 92)
            clock_ms += $urandom_range(25, 400);
        else if (roll < 97)
            clock_ms += $urandom_range(400, 70000);
        else
            clock_ms = $urandom();
        p.now_ms = clock_ms;
        {p.left, p.center, p.right} = 3'($urandom_range(0, 7));

        if (episode == EP_NOISE) begin
            p.toggle  = 1'($urandom_range(0, 1));
            p.dist_cm = 10'($urandom_range(0, 999));
        end else begin
            // mostly stay active, come back quickly when idle
            if (cmds.active)
                p.toggle = ($urandom_range(0, 49) == 0);
            else
                p.toggle = ($urandom_range(0, 2) == 0);
            near_max = (cmds.slow_dist > 999) ? 999 : cmds.slow_dist;
            if (episode == EP_NEAR)
                p.dist_cm = (near_max == 0) ? '0 : 10'($urandom_range(0, near_max - 1));
            else
                p.dist_cm = 10'($urandom_range(near_max, 999));
        end
        return p;
    endfunction

    // hand one pass to the block, idling first as drawn
    task automatic send_pass(input t_pass p);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, p};
        do @(posedge i_clk); while (!o_s_axis_tready);
        cmds.note_pass(p);
    endtask

    // stop sending and wait until every command is back, plus the pipe latency
    task automatic drain_cmds();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (cmds.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one register write per call; the caller drops the enable when done
    task automatic set_reg(input logic [CfgAddrW-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= 16'(val);
        cmds.write_reg(idx, 16'(val));
    endtask

    task automatic load_settings(input int unsigned phase);
        case (phase)
            1: begin
                // every register at its floor, but the ramp step at one
                set_reg(REG_SLOW_DISTANCE, 0);
                set_reg(REG_RAMP_INTERVAL_MS, 0);
                set_reg(REG_RAMP_STEP, 1);
                set_reg(REG_CLEAR_HOLD_MS, 0);
                set_reg(REG_FULL_SPEED, 0);
                set_reg(REG_HARD_TURN_SPEED, 0);
                set_reg(REG_RECOVER_SPEED, 0);
                set_reg(REG_SOFT_TURN_SPEED, 0);
            end
            2: begin
                // every register at its ceiling, but the slow distance at 999
                set_reg(REG_SLOW_DISTANCE, 999);
                set_reg(REG_RAMP_INTERVAL_MS, 1023);
                set_reg(REG_RAMP_STEP, 255);
                set_reg(REG_CLEAR_HOLD_MS, 65535);
                set_reg(REG_FULL_SPEED, 1023);
                set_reg(REG_HARD_TURN_SPEED, 1023);
                set_reg(REG_RECOVER_SPEED, 1023);
                set_reg(REG_SOFT_TURN_SPEED, 1023);
            end
            3: begin
                // short hold and quick ramps so obstacle cycles complete often
                set_reg(REG_SLOW_DISTANCE, $urandom_range(30, 300));
                set_reg(REG_RAMP_INTERVAL_MS, $urandom_range(0, 20));
                set_reg(REG_RAMP_STEP, $urandom_range(20, 120));
                set_reg(REG_CLEAR_HOLD_MS, $urandom_range(0, 200));
                set_reg(REG_FULL_SPEED, $urandom_range(200, 1023));
                set_reg(REG_HARD_TURN_SPEED, $urandom_range(0, 1023));
                set_reg(REG_RECOVER_SPEED, $urandom_range(0, 1023));
                set_reg(REG_SOFT_TURN_SPEED, $urandom_range(0, 1023));
            end
            4: begin
                // zero ramp step leaves the speed frozen during ramps
                set_reg(REG_RAMP_STEP, 0);
                set_reg(REG_SLOW_DISTANCE, $urandom_range(100, 600));
                set_reg(REG_RAMP_INTERVAL_MS, $urandom_range(0, 10));
                set_reg(REG_CLEAR_HOLD_MS, $urandom_range(0, 100));
            end
            default: begin
                set_reg(REG_SLOW_DISTANCE, $urandom_range(0, 999));
                set_reg(REG_RAMP_INTERVAL_MS, $urandom_range(0, 1023));
                set_reg(REG_RAMP_STEP, $urandom_range(1, 255));
                set_reg(REG_CLEAR_HOLD_MS, $urandom_range(0, 65535));
                set_reg(REG_FULL_SPEED, $urandom_range(0, 1023));
                set_reg(REG_HARD_TURN_SPEED, $urandom_range(0, 1023));
                set_reg(REG_RECOVER_SPEED, $urandom_range(0, 1023));
                set_reg(REG_SOFT_TURN_SPEED, $urandom_range(0, 1023));
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // command sink: stall per item as drawn, check every accepted command
    initial begin : command_sink
        int unsigned stall;
        int unsigned seen;
        stall = 0;
        seen  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                cmds.check_cmd(t_result'(o_m_axis_tdata));
                seen++;
                if (seen % 40 == 0)
                    rx_calm = ($urandom_range(0, 3) == 0);
                stall = rx_calm ? 0 : $urandom_range(0, 19);
            end
            @(negedge i_clk);
            if (stall != 0) begin
                i_m_axis_tready <= 1'b0;
                stall--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned k;
        cmds = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sensor table at the reset settings
        send_pass(pass_of(1'b0, SENSE_CENTER, 10'd500, 32'd100));        // idle: stop
        send_pass(pass_of(1'b1, SENSE_NONE, 10'd500, 32'd105));          // all white, never moved
        send_pass(pass_of(1'b0, SENSE_LEFT_RIGHT, 10'd999, 32'd110));    // outer pair black
        send_pass(pass_of(1'b0, SENSE_CENTER, 10'd999, 32'd115));        // straight
        send_pass(pass_of(1'b0, SENSE_LEFT, 10'd998, 32'd120));          // hard right, brakes
        send_pass(pass_of(1'b0, SENSE_RIGHT, 10'd500, 32'd125));         // hard left, no brake
        send_pass(pass_of(1'b0, SENSE_NONE, 10'd500, 32'd130));          // lost line, repeat left
        send_pass(pass_of(1'b0, SENSE_LEFT_CENTER, 10'd500, 32'd135));   // soft right
        send_pass(pass_of(1'b0, SENSE_NONE, 10'd20, 32'd140));           // lost line, repeat right
        send_pass(pass_of(1'b0, SENSE_ALL, 10'd21, 32'd145));            // all black: straight
        send_pass(pass_of(1'b0, SENSE_NONE, 10'd600, 32'd150));          // lost after straight
        send_pass(pass_of(1'b0, SENSE_RIGHT, 10'd600, 32'd155));         // hard left, brakes
        send_pass(pass_of(1'b0, SENSE_CENTER_RIGHT, 10'd600, 32'd160));  // soft left
        send_pass(pass_of(1'b1, SENSE_CENTER, 10'd0, 32'd165));          // back to idle
        drain_cmds();

        // obstacle cycle across the ms wrap: ramp every pass, big steps, short hold
        set_reg(REG_RAMP_INTERVAL_MS, 0);
        set_reg(REG_RAMP_STEP, 255);
        set_reg(REG_CLEAR_HOLD_MS, 20);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        send_pass(pass_of(1'b1, SENSE_CENTER, 10'd999, 32'hFFFF_FFF0));  // full speed
        send_pass(pass_of(1'b0, SENSE_CENTER, 10'd0, 32'hFFFF_FFF2));    // slow down
        send_pass(pass_of(1'b0, SENSE_CENTER, 10'd19, 32'hFFFF_FFF4));   // floor at zero
        send_pass(pass_of(1'b0, SENSE_CENTER, 10'd0, 32'hFFFF_FFF6));    // stays stopped
        send_pass(pass_of(1'b0, SENSE_CENTER, 10'd20, 32'h0000_0004));   // cleared, holding
        send_pass(pass_of(1'b0, SENSE_CENTER, 10'd999, 32'h0000_000A));  // hold over, ramp up
        send_pass(pass_of(1'b0, SENSE_CENTER, 10'd999, 32'h0000_000B));  // clamp at full
        send_pass(pass_of(1'b0, SENSE_NONE, 10'd999, 32'h0000_000C));    // line following again
        clock_ms = 32'h0000_000C;

        // random phases, each under its own register setting
        for (phase = 0; phase < PhaseCount; phase++) begin
            if (phase != 0) begin
                drain_cmds();
                load_settings(phase);
            end
            for (k = 0; k < PhaseItems; k++) begin
                if (k % 40 == 0)
                    tx_calm = ($urandom_range(0, 3) == 0);
                // sender holds off until the block has handed everything back
                if (k == 95 || $urandom_range(0, 59) == 0)
                    drain_cmds();
                send_pass(random_pass());
            end
        end

        drain_cmds();
        repeat (10) @(posedge i_clk);
        $display("checked %0d drive commands over %0d register settings", cmds.n_checked,
                 PhaseCount + 1);
        $display("idle %0d, near obstacle %0d, holding %0d, ramping up %0d, brake turns %0d",
                 cmds.n_idle, cmds.n_near, cmds.n_hold, cmds.n_rise, cmds.n_brake);
        if (cmds.errors == 0 && cmds.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
